### design/udrb_pkg.sv
// ---------------------------------------------------------------------------
// udrb_pkg
// shared types, codes and defaults for the dual uart ring buffer
// ---------------------------------------------------------------------------
package udrb_pkg;

   localparam int RING_DEPTH_DEF = 64;
   localparam int PORT_COUNT_DEF = 2;
   localparam int DATA_W         = 8;

   // request commands
   localparam logic [1:0] CMD_LINE_RX = 2'd0;
   localparam logic [1:0] CMD_HOST_WR = 2'd1;
   localparam logic [1:0] CMD_HOST_RD = 2'd2;
   localparam logic [1:0] CMD_TX_RDY  = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // where the response byte comes from
   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_RX,
      SRC_TX
   } src_type;

   // flags of one response, from the ring control to the output stage
   typedef struct packed {
      logic [1:0] status;
      logic       line_send;
      logic       tx_irq_enable;
      logic       rx_wake;
      logic       tx_wake;
      src_type    src;
   } result_type;

endpackage

### design/udrb_if.sv
// ---------------------------------------------------------------------------
// udrb_if
// request and response channel interfaces with valid/ready handshake
// ---------------------------------------------------------------------------
interface udrb_req_if
   import udrb_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic              channel;
   logic [DATA_W-1:0] data_in;

   modport source (output valid, command, channel, data_in, input ready);
   modport sink   (input valid, command, channel, data_in, output ready);
endinterface

interface udrb_rsp_if
   import udrb_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_out;
   logic [1:0]        status;
   logic              line_send;
   logic              tx_irq_enable;
   logic              rx_wake;
   logic              tx_wake;

   modport source (output valid, data_out, status, line_send, tx_irq_enable, rx_wake,
                   tx_wake, input ready);
   modport sink   (input valid, data_out, status, line_send, tx_irq_enable, rx_wake,
                   tx_wake, output ready);
endinterface

### design/udrb_ram.sv
// ---------------------------------------------------------------------------
// udrb_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module udrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/udrb_ctrl.sv
// ---------------------------------------------------------------------------
// udrb_ctrl
// per channel ring pointers, full/empty decisions and ram access requests
// ---------------------------------------------------------------------------
module udrb_ctrl
   import udrb_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF,
   parameter int PORT_COUNT = PORT_COUNT_DEF,
   localparam int ADDR_W = $clog2(PORT_COUNT * RING_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        command,
   input  logic              channel,
   input  logic [DATA_W-1:0] data_in,
   output logic              rx_wr_en,
   output logic              tx_wr_en,
   output logic [ADDR_W-1:0] rx_wr_addr,
   output logic [ADDR_W-1:0] tx_wr_addr,
   output logic [DATA_W-1:0] wr_data,
   output logic              rx_rd_en,
   output logic              tx_rd_en,
   output logic [ADDR_W-1:0] rx_rd_addr,
   output logic [ADDR_W-1:0] tx_rd_addr,
   output result_type        result
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CH_W  = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

   logic [PTR_W-1:0] rx_rd_ff [PORT_COUNT];
   logic [PTR_W-1:0] rx_wr_ff [PORT_COUNT];
   logic [PTR_W-1:0] tx_rd_ff [PORT_COUNT];
   logic [PTR_W-1:0] tx_wr_ff [PORT_COUNT];
   logic             irq_ff   [PORT_COUNT];
   logic [PTR_W-1:0] rx_rd_in [PORT_COUNT];
   logic [PTR_W-1:0] rx_wr_in [PORT_COUNT];
   logic [PTR_W-1:0] tx_rd_in [PORT_COUNT];
   logic [PTR_W-1:0] tx_wr_in [PORT_COUNT];
   logic             irq_in   [PORT_COUNT];

   logic [CH_W-1:0]  ch_sel;
   logic [PTR_W-1:0] rx_rd, rx_wr, tx_rd, tx_wr;
   logic [PTR_W-1:0] rx_wr_nxt, tx_wr_nxt, rx_rd_nxt, tx_rd_nxt;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] ring_addr(input logic [CH_W-1:0] c,
                                                   input logic [PTR_W-1:0] p);
      return ADDR_W'(c) * ADDR_W'(RING_DEPTH) + ADDR_W'(p);
   endfunction

   // channel taken modulo the port count
   assign ch_sel = (PORT_COUNT > 1) ? CH_W'(channel) : '0;

   assign rx_rd     = rx_rd_ff[ch_sel];
   assign rx_wr     = rx_wr_ff[ch_sel];
   assign tx_rd     = tx_rd_ff[ch_sel];
   assign tx_wr     = tx_wr_ff[ch_sel];
   assign rx_rd_nxt = ring_next(rx_rd);
   assign rx_wr_nxt = ring_next(rx_wr);
   assign tx_rd_nxt = ring_next(tx_rd);
   assign tx_wr_nxt = ring_next(tx_wr);

   assign rx_wr_addr = ring_addr(ch_sel, rx_wr);
   assign tx_wr_addr = ring_addr(ch_sel, tx_wr);
   assign rx_rd_addr = ring_addr(ch_sel, rx_rd);
   assign tx_rd_addr = ring_addr(ch_sel, tx_rd);
   assign wr_data    = data_in;

   always_comb begin
      rx_rd_in = rx_rd_ff;
      rx_wr_in = rx_wr_ff;
      tx_rd_in = tx_rd_ff;
      tx_wr_in = tx_wr_ff;
      irq_in   = irq_ff;
      rx_wr_en = 1'b0;
      tx_wr_en = 1'b0;
      rx_rd_en = 1'b0;
      tx_rd_en = 1'b0;
      result   = '{status: ST_OK, line_send: 1'b0, tx_irq_enable: 1'b0,
                   rx_wake: 1'b0, tx_wake: 1'b0, src: SRC_NONE};
      case (command)
         CMD_LINE_RX: begin
            // full ring drops its oldest byte
            if (rx_wr_nxt == rx_rd) begin
               rx_rd_in[ch_sel] = rx_rd_nxt;
            end
            rx_wr_in[ch_sel] = rx_wr_nxt;
            rx_wr_en         = accept;
            result.rx_wake   = 1'b1;
         end
         CMD_HOST_WR: begin
            if (tx_wr_nxt == tx_rd) begin
               result.status = ST_FULL;
            end else begin
               tx_wr_in[ch_sel] = tx_wr_nxt;
               irq_in[ch_sel]   = 1'b1;
               tx_wr_en         = accept;
            end
         end
         CMD_HOST_RD: begin
            if (rx_rd == rx_wr) begin
               result.status = ST_EMPTY;
            end else begin
               rx_rd_in[ch_sel] = rx_rd_nxt;
               rx_rd_en         = accept;
               result.src       = SRC_RX;
            end
         end
         CMD_TX_RDY: begin
            if (tx_rd == tx_wr) begin
               result.status  = ST_EMPTY;
               irq_in[ch_sel] = 1'b0;
            end else begin
               tx_rd_in[ch_sel] = tx_rd_nxt;
               tx_rd_en         = accept;
               result.src       = SRC_TX;
               result.line_send = 1'b1;
               result.tx_wake   = 1'b1;
            end
         end
         default: begin
            result.status = ST_OK;
         end
      endcase
      result.tx_irq_enable = irq_in[ch_sel];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PORT_COUNT; i++) begin
            rx_rd_ff[i] <= '0;
            rx_wr_ff[i] <= '0;
            tx_rd_ff[i] <= '0;
            tx_wr_ff[i] <= '0;
            irq_ff[i]   <= 1'b0;
         end
      end else if (accept) begin
         rx_rd_ff <= rx_rd_in;
         rx_wr_ff <= rx_wr_in;
         tx_rd_ff <= tx_rd_in;
         tx_wr_ff <= tx_wr_in;
         irq_ff   <= irq_in;
      end
   end

endmodule

### design/uart_dual_ring_buffer.sv
// ---------------------------------------------------------------------------
// uart_dual_ring_buffer
// receive and transmit ring buffers for each port of a multi-port uart
// ---------------------------------------------------------------------------
// usage
//   req_bus carries one request: command (line byte in, host write, host
//   read, transmitter ready), channel and data_in. rsp_bus returns exactly
//   one response per request: data_out, status, line_send, tx_irq_enable,
//   rx_wake and tx_wake.
//   the response is registered and shows in the cycle after its request is
//   taken. a new request can be taken every cycle while the receiver takes
//   responses; the registered read data of the single read port of each
//   ring ram meets the registered response flags in the output stage.
//   each ring holds RING_DEPTH-1 bytes; a line byte into a full receive
//   ring drops the oldest byte, a host write into a full transmit ring is
//   refused with status full.
//   reset clears all ring pointers and transmit interrupt enables at once
//   and empties the output stage; ring contents are not cleared, none is
//   read before it is written.
//   when the receiver stalls, the response holds in the output stage and
//   req_bus.ready drops until it is taken; ready rises again in the cycle
//   the response leaves.
// ---------------------------------------------------------------------------
module uart_dual_ring_buffer
   import udrb_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF,
   parameter int PORT_COUNT = PORT_COUNT_DEF
) (
   input  logic   clock,
   input  logic   reset,
   udrb_req_if.sink   req_bus,
   udrb_rsp_if.source rsp_bus
);

   localparam int STORE_DEPTH = PORT_COUNT * RING_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   logic              accept;
   logic              rx_wr_en, tx_wr_en, rx_rd_en, tx_rd_en;
   logic [ADDR_W-1:0] rx_wr_addr, tx_wr_addr, rx_rd_addr, tx_rd_addr;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] rx_rd_data, tx_rd_data;
   result_type        result;

   // output stage
   logic       valid_ff, valid_in;
   result_type result_ff;

   // take a request whenever the output stage is free or being drained
   assign req_bus.ready = !valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   udrb_ctrl #(
      .RING_DEPTH (RING_DEPTH),
      .PORT_COUNT (PORT_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .command    (req_bus.command),
      .channel    (req_bus.channel),
      .data_in    (req_bus.data_in),
      .rx_wr_en   (rx_wr_en),
      .tx_wr_en   (tx_wr_en),
      .rx_wr_addr (rx_wr_addr),
      .tx_wr_addr (tx_wr_addr),
      .wr_data    (wr_data),
      .rx_rd_en   (rx_rd_en),
      .tx_rd_en   (tx_rd_en),
      .rx_rd_addr (rx_rd_addr),
      .tx_rd_addr (tx_rd_addr),
      .result     (result)
   );

   // receive store, all channels side by side
   udrb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_addr),
      .wr_data (wr_data),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_rd_addr),
      .rd_data (rx_rd_data)
   );

   // transmit store
   udrb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wr_addr),
      .wr_data (wr_data),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // response flags; ram read data holds by itself while no request is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.status        = result_ff.status;
   assign rsp_bus.line_send     = result_ff.line_send;
   assign rsp_bus.tx_irq_enable = result_ff.tx_irq_enable;
   assign rsp_bus.rx_wake       = result_ff.rx_wake;
   assign rsp_bus.tx_wake       = result_ff.tx_wake;

   always_comb begin
      case (result_ff.src)
         SRC_RX:  rsp_bus.data_out = rx_rd_data;
         SRC_TX:  rsp_bus.data_out = tx_rd_data;
         default: rsp_bus.data_out = '0;
      endcase
   end

endmodule

### design/udrb_checker.sv
// ---------------------------------------------------------------------------
// udrb_checker
// port level checks of the dual uart ring buffer, bound to the top level
// ---------------------------------------------------------------------------
module udrb_checker
   import udrb_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic       rsp_line_send,
   input logic       rsp_tx_wake
);

   // a pending response stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // every request taken shows its response in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("response missing one cycle after request");

   // an empty output stage never holds off requests
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with output stage empty");

   // a line transmit pops a byte and wakes writers
   a_send_wake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_send |-> rsp_tx_wake && rsp_status == ST_OK)
      else $error("line send without transmit wake");

endmodule

bind uart_dual_ring_buffer udrb_checker u_udrb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_status    (rsp_bus.status),
   .rsp_line_send (rsp_bus.line_send),
   .rsp_tx_wake   (rsp_bus.tx_wake)
);

### bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for uart_dual_ring_buffer: every accepted request goes
// through a cycle-free copy of the receive and transmit rings of both ports,
// and each response is compared field by field with the oldest prediction
// ---------------------------------------------------------------------------
module tb;
   import udrb_pkg::*;

   localparam int DEPTH          = RING_DEPTH_DEF;
   localparam int PORTS          = PORT_COUNT_DEF;
   localparam int PTR_W          = $clog2(DEPTH);
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 10;

   // one response as the bench predicts it
   typedef struct packed {
      logic [DATA_W-1:0] data_out;
      logic [1:0]        status;
      logic              line_send;
      logic              tx_irq_enable;
      logic              rx_wake;
      logic              tx_wake;
   } rsp_fields_type;

   logic clock;
   logic reset;

   udrb_req_if req_if ();
   udrb_rsp_if rsp_if ();

   uart_dual_ring_buffer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // 12 unit clock period
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // ring state of the bench, head = next byte out, tail = next free slot
   // ------------------------------------------------------------------
   logic [DATA_W-1:0] rx_ring [PORTS][DEPTH];
   logic [DATA_W-1:0] tx_ring [PORTS][DEPTH];
   logic [PTR_W-1:0]  rx_head [PORTS];
   logic [PTR_W-1:0]  rx_tail [PORTS];
   logic [PTR_W-1:0]  tx_head [PORTS];
   logic [PTR_W-1:0]  tx_tail [PORTS];
   logic              tx_irq  [PORTS];

   rsp_fields_type pending_rsp [$];

   // bookkeeping for the closing summary
   int n_sent;
   int n_checked;
   int n_rx_overwrite;
   int n_tx_refused;
   int n_empty_pop;
   int mismatches;

   // side controls shared by the main sequence, the test tasks and the bench processes
   bit gaps_on;
   int hold_left;
   int rsp_burst;
   int quiet_cycles;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   // advance the rings by one request and return the response it should cause
   function automatic rsp_fields_type uart_ring_step(input logic [1:0] cmd,
                                                     input logic ch_in,
                                                     input logic [DATA_W-1:0] byte_in);
      rsp_fields_type   r;
      int               ch;
      logic [PTR_W-1:0] nxt;
      r  = '0;
      ch = int'(ch_in) % PORTS;
      case (cmd)
         CMD_LINE_RX: begin
            // full receive ring: drop the oldest byte, the new one always goes in
            nxt = next_slot(rx_tail[ch]);
            if (nxt == rx_head[ch]) begin
               rx_head[ch] = next_slot(rx_head[ch]);
               n_rx_overwrite++;
            end
            rx_ring[ch][rx_tail[ch]] = byte_in;
            rx_tail[ch] = nxt;
            r.rx_wake = 1'b1;
         end
         CMD_HOST_WR: begin
            // full transmit ring refuses the byte, enable untouched
            nxt = next_slot(tx_tail[ch]);
            if (nxt == tx_head[ch]) begin
               r.status = ST_FULL;
               n_tx_refused++;
            end else begin
               tx_ring[ch][tx_tail[ch]] = byte_in;
               tx_tail[ch] = nxt;
               tx_irq[ch]  = 1'b1;
            end
         end
         CMD_HOST_RD: begin
            if (rx_head[ch] == rx_tail[ch]) begin
               r.status = ST_EMPTY;
               n_empty_pop++;
            end else begin
               r.data_out  = rx_ring[ch][rx_head[ch]];
               rx_head[ch] = next_slot(rx_head[ch]);
            end
         end
         CMD_TX_RDY: begin
            // empty transmit ring turns the interrupt enable off
            if (tx_head[ch] == tx_tail[ch]) begin
               r.status   = ST_EMPTY;
               tx_irq[ch] = 1'b0;
               n_empty_pop++;
            end else begin
               r.data_out  = tx_ring[ch][tx_head[ch]];
               tx_head[ch] = next_slot(tx_head[ch]);
               r.line_send = 1'b1;
               r.tx_wake   = 1'b1;
            end
         end
         default: begin
            r.status = ST_OK;
         end
      endcase
      r.tx_irq_enable = tx_irq[ch];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // request side: drive at the falling edge, accept at the rising edge
   // ------------------------------------------------------------------
   task automatic send_req(input logic [1:0] cmd, input logic ch,
                           input logic [DATA_W-1:0] data);
      int gap;
      @(negedge clock);
      // optional idle burst before this request
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.command <= cmd;
      req_if.channel <= ch;
      req_if.data_in <= data;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      pending_rsp.push_back(uart_ring_step(cmd, ch, data));
      n_sent++;
   endtask

   // stop offering and let every outstanding response come back
   task automatic wait_drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // response side: ready pattern with idle bursts and the long hold-off
   // ------------------------------------------------------------------
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (rsp_burst > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_burst--;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            rsp_burst = $urandom_range(1, 6) - 1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin : rsp_check
      rsp_fields_type got;
      rsp_fields_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.data_out      = rsp_if.data_out;
         got.status        = rsp_if.status;
         got.line_send     = rsp_if.line_send;
         got.tx_irq_enable = rsp_if.tx_irq_enable;
         got.rx_wake       = rsp_if.rx_wake;
         got.tx_wake       = rsp_if.tx_wake;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: data %h status %0d send %b irq %b rxw %b txw %b",
                        got.data_out, got.status, got.line_send, got.tx_irq_enable,
                        got.rx_wake, got.tx_wake);
         end else begin
            want = pending_rsp.pop_front();
            n_checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"response %0d mismatch: data %h/%h status %0d/%0d ",
                            "send %b/%b irq %b/%b rxw %b/%b txw %b/%b (expected/actual)"},
                           n_checked, want.data_out, got.data_out, want.status, got.status,
                           want.line_send, got.line_send, want.tx_irq_enable,
                           got.tx_irq_enable, want.rx_wake, got.rx_wake,
                           want.tx_wake, got.tx_wake);
            end
         end
      end
   end

   // ends the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     quiet_cycles, pending_rsp.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // test tasks
   // ------------------------------------------------------------------

   // empty pops after reset, byte extremes, both channels, enable on and off
   task automatic test_directed();
      send_req(CMD_HOST_RD, 1'b0, 8'hFF);   // read from empty receive ring
      send_req(CMD_TX_RDY,  1'b0, 8'hFF);   // transmit from empty ring, enable stays off
      send_req(CMD_HOST_RD, 1'b1, 8'h00);
      send_req(CMD_TX_RDY,  1'b1, 8'h00);
      send_req(CMD_HOST_WR, 1'b0, 8'h00);   // enable turns on
      send_req(CMD_HOST_WR, 1'b0, 8'hFF);
      send_req(CMD_TX_RDY,  1'b0, 8'h5A);
      send_req(CMD_TX_RDY,  1'b0, 8'hA5);
      send_req(CMD_TX_RDY,  1'b0, 8'h00);   // now empty, enable turns off
      send_req(CMD_LINE_RX, 1'b1, 8'hFF);
      send_req(CMD_LINE_RX, 1'b1, 8'h00);
      send_req(CMD_LINE_RX, 1'b0, 8'hA5);
      send_req(CMD_HOST_RD, 1'b1, 8'h00);
      send_req(CMD_HOST_RD, 1'b0, 8'hFF);
      send_req(CMD_HOST_RD, 1'b1, 8'h3C);
      send_req(CMD_HOST_RD, 1'b1, 8'hC3);   // drained, empty again
      send_req(CMD_HOST_WR, 1'b1, 8'h5A);
      send_req(CMD_TX_RDY,  1'b0, 8'h0F);   // other channel, its enable is independent
      send_req(CMD_HOST_WR, 1'b1, 8'hC3);
      send_req(CMD_TX_RDY,  1'b1, 8'hF0);
      send_req(CMD_TX_RDY,  1'b1, 8'h00);
      send_req(CMD_TX_RDY,  1'b1, 8'hFF);
   endtask

   // overfill each receive ring so old bytes get dropped, then read it dry
   task automatic test_rx_overwrite();
      int n;
      for (int ch = 0; ch < PORTS; ch++) begin
         n = DEPTH - 1 + $urandom_range(1, 8);
         repeat (n) send_req(CMD_LINE_RX, 1'(ch), 8'($urandom));
         repeat (DEPTH + 1) send_req(CMD_HOST_RD, 1'(ch), 8'($urandom));
      end
   endtask

   // overfill each transmit ring so writes get refused, then send it all
   task automatic test_tx_full();
      int n;
      for (int ch = 0; ch < PORTS; ch++) begin
         n = DEPTH - 1 + $urandom_range(1, 8);
         repeat (n) send_req(CMD_HOST_WR, 1'(ch), 8'($urandom));
         repeat (DEPTH + 1) send_req(CMD_TX_RDY, 1'(ch), 8'($urandom));
      end
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_stalled_receiver();
      hold_left = LONG_HOLD;
      repeat (40) send_req(2'($urandom), 1'($urandom), 8'($urandom));
   endtask

   // random traffic in blocks that lean toward filling or draining the rings, or mix all commands
   task automatic test_random_traffic(input int n_items, input bit with_gaps);
      int         mode;
      int         pick;
      logic       home_ch;
      logic       ch;
      logic [1:0] cmd;
      for (int i = 0; i < n_items; i++) begin
         if (i % 30 == 0) begin
            mode    = $urandom_range(0, 2);
            home_ch = 1'($urandom);
            gaps_on = with_gaps && ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 9);
         case (mode)
            0:       cmd = (pick < 4) ? CMD_LINE_RX :
                           (pick < 8) ? CMD_HOST_WR : 2'($urandom);
            1:       cmd = (pick < 4) ? CMD_HOST_RD :
                           (pick < 8) ? CMD_TX_RDY  : 2'($urandom);
            default: cmd = 2'($urandom);
         endcase
         // mostly stay on one channel so a ring actually fills or empties
         ch = ($urandom_range(0, 3) == 0) ? 1'($urandom) : home_ch;
         send_req(cmd, ch, 8'($urandom));
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.command = CMD_LINE_RX;
      req_if.channel = 1'b0;
      req_if.data_in = '0;
      gaps_on        = 1'b0;
      hold_left      = 0;
      rsp_burst      = 0;
      quiet_cycles   = 0;
      n_sent         = 0;
      n_checked      = 0;
      n_rx_overwrite = 0;
      n_tx_refused   = 0;
      n_empty_pop    = 0;
      mismatches     = 0;
      // rings start empty with both transmit enables off
      for (int ch = 0; ch < PORTS; ch++) begin
         rx_head[ch] = '0;
         rx_tail[ch] = '0;
         tx_head[ch] = '0;
         tx_tail[ch] = '0;
         tx_irq[ch]  = 1'b0;
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      gaps_on = 1'b1;
      test_directed();
      test_rx_overwrite();
      test_tx_full();
      test_stalled_receiver();
      test_random_traffic(600, 1'b1);
      // closing stretch runs at full rate on both sides
      gaps_on = 1'b0;
      test_random_traffic(150, 1'b0);
      wait_drain();

      $display("sent %0d requests, checked %0d responses, %0d mismatches",
               n_sent, n_checked, mismatches);
      $display("receive overwrites %0d, transmit refusals %0d, empty pops %0d",
               n_rx_overwrite, n_tx_refused, n_empty_pop);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### uart_dual_ring_buffer.f
design/udrb_pkg.sv
design/udrb_if.sv
design/udrb_ram.sv
design/udrb_ctrl.sv
design/uart_dual_ring_buffer.sv
design/udrb_checker.sv
bench/tb.sv
